// File: hw/rtl/mkdlp_pkg.sv
package mkdlp_pkg;

   // field widths of the channels and registers
   localparam int KEY_SLOTS   = 4;
   localparam int EVENT_W     = 2;
   localparam int EVENTS_W    = KEY_SLOTS * EVENT_W;
   localparam int DELAY_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_ENABLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_DELAY   = 2'd2;

   // register reset values
   localparam logic [KEY_SLOTS-1:0] KEY_ENABLE_RST   = 4'hF;
   localparam logic [KEY_SLOTS-1:0] ACTIVE_LEVEL_RST = 4'hF;
   localparam logic [DELAY_W-1:0]   LONG_DELAY_RST   = 16'd100;

   // per-key phase
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_CONFIRM = 2'd1,
      PH_DOWN    = 2'd2,
      PH_LONG    = 2'd3
   } phase_type;

   // per-key event code
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE = 2'd0,
      EV_DOWN = 2'd1,
      EV_UP   = 2'd2,
      EV_LONG = 2'd3
   } event_type;

   // what one lane sees of the current item
   typedef struct packed {
      logic advance;
      logic enable;
      logic level;
      logic pin;
   } lane_ctrl_type;

endpackage

// File: hw/rtl/mkdlp_lane.sv
module mkdlp_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  mkdlp_pkg::lane_ctrl_type      ctrl,
   input  logic [mkdlp_pkg::DELAY_W-1:0] long_delay,
   output mkdlp_pkg::event_type          step_event
);

   mkdlp_pkg::phase_type          phase_ff, phase_in;
   logic [mkdlp_pkg::DELAY_W-1:0] hold_ff, hold_in;
   logic                          pressed_ff, pressed_in;
   logic [mkdlp_pkg::DELAY_W-1:0] hold_inc;
   logic                          hold_done;

   // sampled pressed flag, frozen while the key is disabled
   assign pressed_in = ctrl.enable ? (ctrl.pin == ctrl.level) : pressed_ff;

   assign hold_inc  = hold_ff + 1'b1;
   assign hold_done = (hold_inc >= long_delay);

   // next phase, hold count and event
   always_comb begin
      phase_in   = phase_ff;
      hold_in    = hold_ff;
      step_event = mkdlp_pkg::EV_NONE;
      case (phase_ff)
         mkdlp_pkg::PH_IDLE: begin
            if (pressed_in) phase_in = mkdlp_pkg::PH_CONFIRM;
         end
         mkdlp_pkg::PH_CONFIRM: begin
            if (pressed_in) begin
               phase_in   = mkdlp_pkg::PH_DOWN;
               hold_in    = '0;
               step_event = mkdlp_pkg::EV_DOWN;
            end else begin
               phase_in = mkdlp_pkg::PH_IDLE;
            end
         end
         mkdlp_pkg::PH_DOWN: begin
            if (!pressed_in) begin
               phase_in   = mkdlp_pkg::PH_IDLE;
               step_event = mkdlp_pkg::EV_UP;
            end else if (hold_done) begin
               phase_in   = mkdlp_pkg::PH_LONG;
               hold_in    = '0;
               step_event = mkdlp_pkg::EV_LONG;
            end else begin
               hold_in = hold_inc;
            end
         end
         mkdlp_pkg::PH_LONG: begin
            if (!pressed_in) begin
               phase_in = mkdlp_pkg::PH_IDLE;
            end else if (hold_done) begin
               hold_in    = '0;
               step_event = mkdlp_pkg::EV_LONG;
            end else begin
               hold_in = hold_inc;
            end
         end
         default: begin
            phase_in = mkdlp_pkg::PH_IDLE;
         end
      endcase
   end

   // key state, stepped once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mkdlp_pkg::PH_IDLE;
         hold_ff    <= '0;
         pressed_ff <= 1'b0;
      end else if (ctrl.advance) begin
         phase_ff   <= phase_in;
         hold_ff    <= hold_in;
         pressed_ff <= pressed_in;
      end
   end

endmodule

// File: hw/rtl/mkdlp_merge.sv
module mkdlp_merge #(
   parameter int NUM_KEYS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           take,
   input  mkdlp_pkg::event_type           lane_event [NUM_KEYS],
   output logic                           out_valid,
   output logic [mkdlp_pkg::EVENTS_W-1:0] out_events
);

   logic [mkdlp_pkg::EVENTS_W-1:0] events_in;
   logic [mkdlp_pkg::EVENTS_W-1:0] events_ff;
   logic                           valid_ff;

   // pack the lanes that have a slot in the result word
   for (genvar k = 0; k < mkdlp_pkg::KEY_SLOTS; k++) begin : g_slot
      if (k < NUM_KEYS) begin : g_used
         assign events_in[k*mkdlp_pkg::EVENT_W +: mkdlp_pkg::EVENT_W] = lane_event[k];
      end else begin : g_empty
         assign events_in[k*mkdlp_pkg::EVENT_W +: mkdlp_pkg::EVENT_W] = mkdlp_pkg::EV_NONE;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) events_ff <= events_in;
   end

   assign out_valid  = valid_ff;
   assign out_events = events_ff;

endmodule

// File: hw/rtl/multi_key_debounce_long_press_core.sv
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------
// req      | req_valid / req_stall | req_pin_levels[3:0]
// rsp      | rsp_valid / rsp_stall | rsp_key_events[7:0]
// csr      | csr_valid / csr_ready | csr_index[1:0], csr_data[15:0]
//
// one item per cycle while req_stall is low; its result is in the output
// register the cycle after it is taken, set by each lane's per-key step.
// reset is synchronous: all keys idle, hold counts and flags zero, registers
// at their defaults. req_stall rises only while a result waits and rsp_stall
// is high; csr_ready is always high.
module multi_key_debounce_long_press_core #(
   parameter int NUM_KEYS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mkdlp_pkg::KEY_SLOTS-1:0]   req_pin_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mkdlp_pkg::EVENTS_W-1:0]    rsp_key_events,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mkdlp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mkdlp_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [mkdlp_pkg::KEY_SLOTS-1:0] key_enable_ff;
   logic [mkdlp_pkg::KEY_SLOTS-1:0] active_level_ff;
   logic [mkdlp_pkg::DELAY_W-1:0]   long_delay_ff;
   logic                            accept;
   mkdlp_pkg::event_type            lane_event [NUM_KEYS];

   // handshake: take an item whenever the output register can be refilled
   assign req_stall = rsp_valid & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_enable_ff   <= mkdlp_pkg::KEY_ENABLE_RST;
         active_level_ff <= mkdlp_pkg::ACTIVE_LEVEL_RST;
         long_delay_ff   <= mkdlp_pkg::LONG_DELAY_RST;
      end else if (csr_valid) begin
         case (csr_index)
            mkdlp_pkg::CSR_KEY_ENABLE:
               key_enable_ff <= csr_data[mkdlp_pkg::KEY_SLOTS-1:0];
            mkdlp_pkg::CSR_ACTIVE_LEVEL:
               active_level_ff <= csr_data[mkdlp_pkg::KEY_SLOTS-1:0];
            mkdlp_pkg::CSR_LONG_DELAY:
               long_delay_ff <= csr_data[mkdlp_pkg::DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // one lane per key; keys without a pin stay disabled
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      mkdlp_pkg::lane_ctrl_type ctrl;

      if (k < mkdlp_pkg::KEY_SLOTS) begin : g_pin
         assign ctrl = '{advance: accept,
                         enable:  key_enable_ff[k],
                         level:   active_level_ff[k],
                         pin:     req_pin_levels[k]};
      end else begin : g_nopin
         assign ctrl = '{advance: accept, enable: 1'b0, level: 1'b0, pin: 1'b0};
      end

      mkdlp_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .long_delay (long_delay_ff),
         .step_event (lane_event[k])
      );
   end

   // pack lane events into the result register
   mkdlp_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .take       (~rsp_stall),
      .lane_event (lane_event),
      .out_valid  (rsp_valid),
      .out_events (rsp_key_events)
   );

endmodule
